>>> hdl/ssc_pkg.sv
// Shared types, constants and helper functions for the shot clock countdown.
// No dependencies; imported by every module of the block.

package ssc_pkg;

	localparam int CountW = 7;
	localparam int PhaseW = 6;
	localparam int SegW = 7;
	localparam int CfgIdxW = 2;

	localparam logic [CountW-1:0] FullPresetRst = 7'd24;
	localparam logic [CountW-1:0] AltPresetRst = 7'd14;
	localparam logic [CountW-1:0] TicksPerSecRst = 7'd64;
	localparam logic [CountW-1:0] PhaseLimitMax = 7'd64;
	localparam logic [CountW-1:0] CountShowMax = 7'd99;
	localparam logic [SegW-1:0] SegAllOn = 7'h7F;
	localparam logic [SegW-1:0] SegBlank = 7'h00;

	// reciprocal of ten for values up to 127: (c * 205) >> 11
	localparam logic [7:0] DivTenMul = 8'd205;
	localparam int DivTenShift = 11;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FULL_PRESET = 2'd0,
		CFG_ALT_PRESET = 2'd1,
		CFG_TICKS_PER_SEC = 2'd2,
		CFG_UNUSED = 2'd3
	} cfg_idx_t;

	// one scan pass: tick and button levels
	typedef struct packed {
		logic tick;
		logic start_pressed;
		logic alt_start_pressed;
		logic run_toggle_pressed;
		logic plus_pressed;
		logic minus_pressed;
		logic indicator_toggle_pressed;
		logic horn_pressed;
	} ssc_item_t;

	typedef struct packed {
		logic [CountW-1:0] full_preset;
		logic [CountW-1:0] alt_preset;
		logic [CountW-1:0] ticks_per_second;
	} ssc_cfg_t;

	// counter state after a pass
	typedef struct packed {
		logic [CountW-1:0] seconds;
		logic counting;
		logic indicator;
	} ssc_status_t;

	typedef logic [SegW-1:0] seg_rom_t [10];

	// segments a..g in bits 0..6
	localparam seg_rom_t SegRom = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h07, 7'h7F, 7'h67
	};

	function automatic logic [3:0] div_ten(input logic [CountW-1:0] c);
		logic [14:0] prod;
		prod = 15'(c) * 15'(DivTenMul);
		return 4'(prod >> DivTenShift);
	endfunction

endpackage

>>> hdl/shot_clock_countdown.sv
// Top level of the shot clock countdown: input register, config registers,
// result register. Depends on ssc_pkg, ssc_state and ssc_seg_decode.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word per button-scan pass,
//    holding the tick flag and the button levels.
//  - Output channel (out_valid / out_stall): one word per input word with
//    both digit segment patterns, the seconds count, running, indicator
//    and horn state after that pass.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): writes
//    full preset, alternate preset and ticks per second; cfg_ready is
//    always high, unknown indices are dropped. Write only while idle.
//  - Path: an accepted word passes the input register, then the result
//    register, whose contents drive the outputs.
//  - Throughput: one word per cycle while the output is not stalled;
//    the state update between the two registers is combinational.
//  - A stalled output holds its word; the input register then holds one
//    more word and in_stall rises until the output drains.
//  - Reset clears both channels and loads count 24, stopped, phase 0, and
//    the config registers to 24, 14 and 64.

module shot_clock_countdown (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         tick,
	input  logic                         start_pressed,
	input  logic                         alt_start_pressed,
	input  logic                         run_toggle_pressed,
	input  logic                         plus_pressed,
	input  logic                         minus_pressed,
	input  logic                         indicator_toggle_pressed,
	input  logic                         horn_pressed,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ssc_pkg::SegW-1:0]     left_segments,
	output logic [ssc_pkg::SegW-1:0]     right_segments,
	output logic [ssc_pkg::CountW-1:0]   seconds_left,
	output logic                         running,
	output logic                         indicator_on,
	output logic                         horn_on,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ssc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ssc_pkg::CountW-1:0]   cfg_data
);
	import ssc_pkg::*;

	logic valid_s1;
	ssc_item_t item_s1;
	ssc_item_t item_in;
	ssc_cfg_t cfg_q;
	ssc_status_t status_next;
	logic [SegW-1:0] left_seg;
	logic [SegW-1:0] right_seg;
	logic advance;
	logic out_valid_q;

	assign item_in = '{
		tick: tick,
		start_pressed: start_pressed,
		alt_start_pressed: alt_start_pressed,
		run_toggle_pressed: run_toggle_pressed,
		plus_pressed: plus_pressed,
		minus_pressed: minus_pressed,
		indicator_toggle_pressed: indicator_toggle_pressed,
		horn_pressed: horn_pressed
	};

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_preset <= FullPresetRst;
			cfg_q.alt_preset <= AltPresetRst;
			cfg_q.ticks_per_second <= TicksPerSecRst;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FULL_PRESET:   cfg_q.full_preset <= cfg_data;
				CFG_ALT_PRESET:    cfg_q.alt_preset <= cfg_data;
				CFG_TICKS_PER_SEC: cfg_q.ticks_per_second <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= item_in;
	end

	ssc_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.item        (item_s1),
		.cfg         (cfg_q),
		.status_next (status_next)
	);

	ssc_seg_decode u_decode (
		.count     (status_next.seconds),
		.left_seg  (left_seg),
		.right_seg (right_seg)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_segments <= left_seg;
			right_segments <= right_seg;
			seconds_left <= status_next.seconds;
			running <= status_next.counting;
			indicator_on <= status_next.indicator;
			horn_on <= item_s1.horn_pressed;
		end
	end

endmodule

>>> hdl/ssc_seg_decode.sv
// Two-digit seven-segment decode of the seconds count, blanking rules included.
// Depends on ssc_pkg (segment table, divide-by-ten helper).

module ssc_seg_decode (
	input  logic [ssc_pkg::CountW-1:0] count,
	output logic [ssc_pkg::SegW-1:0]   left_seg,
	output logic [ssc_pkg::SegW-1:0]   right_seg
);
	import ssc_pkg::*;

	logic [3:0] tens;
	logic [3:0] units;
	logic [CountW-1:0] tens_x10;

	always_comb begin
		tens = div_ten(count);
		tens_x10 = 7'(({3'b000, tens} << 3) + ({3'b000, tens} << 1));
		units = 4'(count - tens_x10);
		if (count > CountShowMax) begin
			left_seg = SegAllOn;
			right_seg = SegAllOn;
		end else begin
			left_seg = (tens == 4'd0) ? SegBlank : SegRom[tens];
			right_seg = (count == '0) ? SegBlank : SegRom[units];
		end
	end

endmodule

>>> hdl/ssc_state.sv
// Counter state registers and the per-pass update: prescaler, second handling,
// buttons. Depends on ssc_pkg (item, config and status structs).

module ssc_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ssc_pkg::ssc_item_t  item,
	input  ssc_pkg::ssc_cfg_t   cfg,
	output ssc_pkg::ssc_status_t status_next
);
	import ssc_pkg::*;

	logic [PhaseW-1:0] phase_q;
	logic [CountW-1:0] seconds_q;
	logic counting_q;
	logic indicator_q;
	logic last_plus_q;
	logic last_minus_q;

	logic [PhaseW-1:0] phase_d;
	logic [CountW-1:0] limit;
	logic [CountW-1:0] phase_inc;
	logic second_end;
	logic [CountW:0] sec_val;
	logic [CountW-1:0] seconds_d;
	logic counting_d;

	always_comb begin
		if (cfg.ticks_per_second == '0)
			limit = 7'd1;
		else if (cfg.ticks_per_second > PhaseLimitMax)
			limit = PhaseLimitMax;
		else
			limit = cfg.ticks_per_second;

		phase_inc = 7'(phase_q) + 7'd1;
		second_end = item.tick && (phase_inc >= limit);

		phase_d = phase_q;
		if (item.tick)
			phase_d = second_end ? '0 : phase_inc[PhaseW-1:0];

		// one second: unsigned arithmetic with one extra bit that flags underflow
		sec_val = {1'b0, seconds_q};
		counting_d = counting_q;
		if (counting_q)
			sec_val = sec_val - 8'd1;
		if (!counting_q && last_plus_q && (seconds_q < cfg.full_preset))
			sec_val = sec_val + 8'd1;
		if (!counting_q && last_minus_q)
			sec_val = sec_val - 8'd1;

		seconds_d = seconds_q;
		if (second_end) begin
			if (sec_val[CountW]) begin
				counting_d = 1'b0;
				seconds_d = cfg.full_preset;
			end else begin
				seconds_d = sec_val[CountW-1:0];
			end
		end

		if (item.start_pressed) begin
			seconds_d = cfg.full_preset;
			phase_d = '0;
			counting_d = 1'b1;
		end
		if (item.alt_start_pressed) begin
			seconds_d = cfg.alt_preset;
			phase_d = '0;
			counting_d = 1'b1;
		end
		if (item.run_toggle_pressed)
			counting_d = !counting_d;

		status_next.seconds = seconds_d;
		status_next.counting = counting_d;
		status_next.indicator = indicator_q ^ item.indicator_toggle_pressed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			seconds_q <= FullPresetRst;
			counting_q <= 1'b0;
			indicator_q <= 1'b0;
			last_plus_q <= 1'b0;
			last_minus_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			seconds_q <= status_next.seconds;
			counting_q <= status_next.counting;
			indicator_q <= status_next.indicator;
			last_plus_q <= item.plus_pressed;
			last_minus_q <= item.minus_pressed;
		end
	end

endmodule

>>> bench/tb_shot_clock_countdown.sv
`timescale 1ns / 100ps
// Self-checking bench for shot_clock_countdown: directed table, then random passes.
// Depends on ssc_pkg and the shot_clock_countdown RTL; a local model predicts every word.

module tb_shot_clock_countdown;

	import ssc_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int RandPhases = 13;
	localparam int PhaseItems = 150;
	localparam int DrillLen = 27;
	// first row of each directed segment that needs new register values
	localparam int RowsMid = 9;
	localparam int RowsWide = 19;
	localparam int RowsSlow = 23;
	localparam int RowsShort = 26;

	typedef struct packed {
		logic [SegW-1:0]   left;
		logic [SegW-1:0]   right;
		logic [CountW-1:0] secs;
		logic              run;
		logic              lamp;
		logic              horn;
	} shot_view_t;

	typedef struct packed {
		ssc_item_t  w;
		logic       typed;
		shot_view_t v;
	} drill_row_t;

	// item bits: tick start alt run plus minus ind horn
	// view: left right seconds {running indicator horn}
	localparam drill_row_t DrillRows [DrillLen] = '{
		{8'b0000_0000, 1'b1, 7'h5B, 7'h66, 7'd24, 3'b000},
		{8'b0000_0001, 1'b1, 7'h5B, 7'h66, 7'd24, 3'b001},
		{8'b0000_0010, 1'b1, 7'h5B, 7'h66, 7'd24, 3'b010},
		{8'b0000_0011, 1'b1, 7'h5B, 7'h66, 7'd24, 3'b001},
		{8'b0001_0000, 1'b1, 7'h5B, 7'h66, 7'd24, 3'b100},
		{8'b0010_0000, 1'b1, 7'h06, 7'h66, 7'd14, 3'b100},
		{8'b0110_0000, 1'b1, 7'h06, 7'h66, 7'd14, 3'b100},
		{8'b0101_0000, 1'b1, 7'h5B, 7'h66, 7'd24, 3'b000},
		{8'b1111_1111, 1'b0, 24'd0},
		// full 5, alt 0, one tick per second
		{8'b0100_0000, 1'b1, 7'h00, 7'h6D, 7'd5, 3'b110},
		{8'b1000_0000, 1'b0, 24'd0},
		{8'b0001_1000, 1'b0, 24'd0},
		{8'b1000_1100, 1'b0, 24'd0},
		{8'b1000_1100, 1'b0, 24'd0},
		{8'b1000_1100, 1'b0, 24'd0},
		{8'b0010_0000, 1'b1, 7'h00, 7'h00, 7'd0, 3'b110},
		{8'b1000_0000, 1'b1, 7'h00, 7'h6D, 7'd5, 3'b010},
		{8'b0011_0100, 1'b1, 7'h00, 7'h00, 7'd0, 3'b010},
		{8'b1000_0000, 1'b1, 7'h00, 7'h6D, 7'd5, 3'b010},
		// full 127, alt 99, zero rate acts as one
		{8'b0100_0000, 1'b1, 7'h7F, 7'h7F, 7'd127, 3'b110},
		{8'b0010_0000, 1'b1, 7'h67, 7'h67, 7'd99, 3'b110},
		{8'b0001_1000, 1'b0, 24'd0},
		{8'b1000_1000, 1'b0, 24'd0},
		// rate above the cap, phase walks up
		{8'b1000_0000, 1'b0, 24'd0},
		{8'b1000_0000, 1'b0, 24'd0},
		{8'b1000_0000, 1'b0, 24'd0},
		// limit lowered below the phase
		{8'b1000_0000, 1'b0, 24'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall;
	logic tick, start_pressed, alt_start_pressed, run_toggle_pressed;
	logic plus_pressed, minus_pressed, indicator_toggle_pressed, horn_pressed;
	logic out_valid, out_stall;
	logic [SegW-1:0] left_segments, right_segments;
	logic [CountW-1:0] seconds_left;
	logic running, indicator_on, horn_on;
	logic cfg_valid, cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CountW-1:0] cfg_data;

	// predictor state and register copy
	logic [PhaseW-1:0] phase_q;
	logic [CountW-1:0] secs_q;
	bit run_q, lamp_q, plus_q, minus_q;
	logic [CountW-1:0] preset_full, preset_alt, tick_rate;

	shot_view_t expected_views [$];
	int fail_count = 0;
	bit idle_en = 1'b0;

	shot_clock_countdown i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.tick(tick),
		.start_pressed(start_pressed),
		.alt_start_pressed(alt_start_pressed),
		.run_toggle_pressed(run_toggle_pressed),
		.plus_pressed(plus_pressed),
		.minus_pressed(minus_pressed),
		.indicator_toggle_pressed(indicator_toggle_pressed),
		.horn_pressed(horn_pressed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_segments(left_segments),
		.right_segments(right_segments),
		.seconds_left(seconds_left),
		.running(running),
		.indicator_on(indicator_on),
		.horn_on(horn_on),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic shot_view_t predict_pass(input ssc_item_t w);
		int lim;
		int c;
		shot_view_t v;
		if (w.tick) begin
			if (tick_rate == 0)
				lim = 1;
			else if (tick_rate > PhaseLimitMax)
				lim = PhaseLimitMax;
			else
				lim = tick_rate;
			if (int'(phase_q) + 1 >= lim) begin
				phase_q = '0;
				c = secs_q;
				// plus and minus use the levels of the previous pass
				if (run_q) begin
					c--;
				end else begin
					if (plus_q && c < int'(preset_full))
						c++;
					if (minus_q)
						c--;
				end
				if (c < 0) begin
					run_q = 1'b0;
					c = preset_full;
				end
				secs_q = c[CountW-1:0];
			end else begin
				phase_q = phase_q + 1'b1;
			end
		end
		if (w.start_pressed) begin
			secs_q = preset_full;
			phase_q = '0;
			run_q = 1'b1;
		end
		if (w.alt_start_pressed) begin
			secs_q = preset_alt;
			phase_q = '0;
			run_q = 1'b1;
		end
		if (w.run_toggle_pressed)
			run_q = !run_q;
		if (w.indicator_toggle_pressed)
			lamp_q = !lamp_q;
		plus_q = w.plus_pressed;
		minus_q = w.minus_pressed;

		v.secs = secs_q;
		if (secs_q > CountShowMax) begin
			v.left = SegAllOn;
			v.right = SegAllOn;
		end else begin
			v.left = (secs_q / 10 == 0) ? SegBlank : SegRom[4'(secs_q / 10)];
			v.right = (secs_q == 0) ? SegBlank : SegRom[4'(secs_q % 10)];
		end
		v.run = run_q;
		v.lamp = lamp_q;
		v.horn = w.horn_pressed;
		return v;
	endfunction

	// drives one pass word, queues its view at acceptance, then maybe idles
	task automatic send_pass(input ssc_item_t w, input logic typed, input shot_view_t typed_view);
		shot_view_t v;
		in_valid <= 1'b1;
		tick <= w.tick;
		start_pressed <= w.start_pressed;
		alt_start_pressed <= w.alt_start_pressed;
		run_toggle_pressed <= w.run_toggle_pressed;
		plus_pressed <= w.plus_pressed;
		minus_pressed <= w.minus_pressed;
		indicator_toggle_pressed <= w.indicator_toggle_pressed;
		horn_pressed <= w.horn_pressed;
		do @(posedge clk); while (in_stall);
		v = predict_pass(w);
		expected_views.push_back(typed ? typed_view : v);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CountW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FULL_PRESET: preset_full = data;
			CFG_ALT_PRESET: preset_alt = data;
			CFG_TICKS_PER_SEC: tick_rate = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CountW-1:0] full, input logic [CountW-1:0] alt,
			input logic [CountW-1:0] rate, input bit poke_unused);
		drain_results();
		write_reg(CFG_FULL_PRESET, full);
		write_reg(CFG_ALT_PRESET, alt);
		write_reg(CFG_TICKS_PER_SEC, rate);
		if (poke_unused)
			write_reg(CFG_UNUSED, CountW'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CountW-1:0] pick_preset();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd127;
			2: return 7'd99;
			3: return CountW'($urandom_range(100, 127));
			default: return CountW'($urandom_range(1, 12));
		endcase
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		shot_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_views.size() == 0) begin
				fail_count++;
				$display("%0t: result word expected none actual seconds_left %0d",
					$time, seconds_left);
			end else begin
				want = expected_views.pop_front();
				check_field("left_segments", want.left, left_segments);
				check_field("right_segments", want.right, right_segments);
				check_field("seconds_left", want.secs, seconds_left);
				check_field("running", want.run, running);
				check_field("indicator_on", want.lamp, indicator_on);
				check_field("horn_on", want.horn, horn_on);
			end
		end
	end

	initial begin : sink_stall
		int burst;
		burst = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		ssc_item_t w;
		logic [CountW-1:0] rate;
		bit hold_plus, hold_minus;
		int r, ph, k;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		tick <= 1'b0;
		start_pressed <= 1'b0;
		alt_start_pressed <= 1'b0;
		run_toggle_pressed <= 1'b0;
		plus_pressed <= 1'b0;
		minus_pressed <= 1'b0;
		indicator_toggle_pressed <= 1'b0;
		horn_pressed <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_FULL_PRESET;
		cfg_data <= '0;

		phase_q = '0;
		secs_q = FullPresetRst;
		run_q = 1'b0;
		lamp_q = 1'b0;
		plus_q = 1'b0;
		minus_q = 1'b0;
		preset_full = FullPresetRst;
		preset_alt = AltPresetRst;
		tick_rate = TicksPerSecRst;
		hold_plus = 1'b0;
		hold_minus = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_en = 1'b1;
		for (r = 0; r < DrillLen; r++) begin
			case (r)
				RowsMid: set_config(7'd5, 7'd0, 7'd1, 1'b0);
				RowsWide: set_config(7'd127, 7'd99, 7'd0, 1'b1);
				RowsSlow: set_config(preset_full, preset_alt, 7'd127, 1'b0);
				RowsShort: set_config(preset_full, preset_alt, 7'd2, 1'b0);
				default: ;
			endcase
			send_pass(DrillRows[r].w, DrillRows[r].typed, DrillRows[r].v);
		end

		for (ph = 0; ph < RandPhases; ph++) begin
			case ($urandom_range(0, 9))
				0: rate = 7'd0;
				1: rate = 7'd127;
				2: rate = PhaseLimitMax;
				3: rate = CountW'($urandom_range(1, 64));
				default: rate = CountW'($urandom_range(1, 4));
			endcase
			set_config(pick_preset(), pick_preset(), rate, bit'($urandom_range(0, 1)));
			// no idling in the closing phase, and now and then a calm one
			idle_en = (ph != RandPhases - 1) && ($urandom_range(0, 3) != 0);
			for (k = 0; k < PhaseItems; k++) begin
				if ($urandom_range(0, 7) == 0)
					hold_plus = !hold_plus;
				if ($urandom_range(0, 7) == 0)
					hold_minus = !hold_minus;
				w.tick = 1'($urandom_range(0, 1));
				w.start_pressed = ($urandom_range(0, 29) == 0);
				w.alt_start_pressed = ($urandom_range(0, 29) == 0);
				w.run_toggle_pressed = ($urandom_range(0, 11) == 0);
				w.plus_pressed = hold_plus;
				w.minus_pressed = hold_minus;
				w.indicator_toggle_pressed = ($urandom_range(0, 7) == 0);
				w.horn_pressed = 1'($urandom_range(0, 1));
				send_pass(w, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
